// File: hw/rtl/bilinear_image_resize_defines.svh
// Assertion macros for the bilinear resize RTL.
// Uses the clk and rst_n names of the module that expands them.
`ifndef BILINEAR_IMAGE_RESIZE_DEFINES_SVH
`define BILINEAR_IMAGE_RESIZE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BIR_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define BIR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BIR_ASSERT(lbl, prop)
`define BIR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: hw/rtl/bir_pkg.sv
// Types and constants of the bilinear resize block.
// No dependencies.
package bir_pkg;

    localparam int MAX_IN_W   = 128;
    localparam int MAX_IN_H   = 128;
    localparam int MAX_OUT_W  = 1024;
    localparam int MAX_OUT_H  = 1024;
    localparam int PIXEL_BITS = 16;

    // register widths
    localparam int IN_SZ_W  = 8;
    localparam int OUT_SZ_W = 11;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam int COL_W  = $clog2(MAX_IN_W);
    localparam int ROW_W  = $clog2(MAX_IN_H);
    localparam int IDX_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
    localparam int ADDR_W = COL_W + ROW_W;
    localparam int DEPTH  = MAX_IN_W * MAX_IN_H;

    localparam int OCOL_W = $clog2(MAX_OUT_W);
    localparam int OROW_W = $clog2(MAX_OUT_H);
    localparam int ODIM_W = (OCOL_W > OROW_W) ? OCOL_W : OROW_W;

    // coordinate arithmetic
    localparam int FRAC_W     = 16;
    localparam int WT_W       = FRAC_W + 1;
    localparam int W_W        = 2 * FRAC_W + 1;
    localparam int NUM_W      = ODIM_W + 1 + IN_SZ_W;
    localparam int DIVIDEND_W = NUM_W + FRAC_W;
    localparam int DEN_W      = OUT_SZ_W + 1;
    localparam int STEP_W     = $clog2(DIVIDEND_W + 1);
    localparam int ACC_W      = PIXEL_BITS + 2 * FRAC_W;
    localparam logic [WT_W-1:0] ONE_Q = WT_W'(1) << FRAC_W;

    localparam int TAPS   = 4;
    localparam int TAP_W  = 3;
    localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(TAPS + 1);

    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);
    localparam int QCNT_W  = $clog2(Q_DEPTH + 1);

    localparam int OUT_TDATA_W = ((PIXEL_BITS + OCOL_W + OROW_W + 7) / 8) * 8;

    typedef enum logic [1:0] {
        REG_IN_WIDTH,
        REG_IN_HEIGHT,
        REG_OUT_WIDTH,
        REG_OUT_HEIGHT
    } reg_idx_t;

    typedef enum logic {
        OP_LOAD,
        OP_EMIT
    } op_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_PREP,
        B_START,
        B_DIV,
        B_ADDR,
        B_MAC,
        B_RES
    } bstate_t;

    typedef struct packed {
        op_t                    op;
        logic [PIXEL_BITS-1:0]  pixel;
    } item_t;

    typedef struct packed {
        logic [IN_SZ_W-1:0]  in_w;
        logic [IN_SZ_W-1:0]  in_h;
        logic [OUT_SZ_W-1:0] out_w;
        logic [OUT_SZ_W-1:0] out_h;
        logic                restart;
    } cfg_t;

    typedef struct packed {
        logic [IDX_W-1:0] idx;
        logic [WT_W-1:0]  wt;
    } coord_t;

    function automatic logic [IN_SZ_W-1:0] clamp_in(logic [IN_SZ_W-1:0] v,
                                                    logic [IN_SZ_W-1:0] hi);
        logic [IN_SZ_W-1:0] r;
        if (v < IN_SZ_W'(2))
            r = IN_SZ_W'(2);
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

    function automatic logic [OUT_SZ_W-1:0] clamp_out(logic [OUT_SZ_W-1:0] v,
                                                      logic [OUT_SZ_W-1:0] hi);
        logic [OUT_SZ_W-1:0] r;
        if (v < OUT_SZ_W'(1))
            r = OUT_SZ_W'(1);
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

endpackage

// File: hw/rtl/bir_front.sv
// Front end: APB register file, size clamping and input classification.
// Depends on bir_pkg.
module bir_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [bir_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [bir_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [bir_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                               pready,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [bir_pkg::PIXEL_BITS-1:0]     s_axis_tdata,  // pixel_in
    input  logic                               s_axis_tuser,  // operation
    output logic                               push,
    output bir_pkg::item_t                     push_item,
    input  logic                               full,
    output bir_pkg::cfg_t                      cfg
);

    logic [bir_pkg::IN_SZ_W-1:0]  in_width_reg;
    logic [bir_pkg::IN_SZ_W-1:0]  in_height_reg;
    logic [bir_pkg::OUT_SZ_W-1:0] out_width_reg;
    logic [bir_pkg::OUT_SZ_W-1:0] out_height_reg;
    logic                         wr;
    bir_pkg::reg_idx_t            idx;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign idx    = bir_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_width_reg   <= bir_pkg::IN_SZ_W'(128);
            in_height_reg  <= bir_pkg::IN_SZ_W'(128);
            out_width_reg  <= bir_pkg::OUT_SZ_W'(128);
            out_height_reg <= bir_pkg::OUT_SZ_W'(128);
        end
        else if (wr)
        begin
            unique case (idx)
                bir_pkg::REG_IN_WIDTH:   in_width_reg   <= pwdata[bir_pkg::IN_SZ_W-1:0];
                bir_pkg::REG_IN_HEIGHT:  in_height_reg  <= pwdata[bir_pkg::IN_SZ_W-1:0];
                bir_pkg::REG_OUT_WIDTH:  out_width_reg  <= pwdata[bir_pkg::OUT_SZ_W-1:0];
                bir_pkg::REG_OUT_HEIGHT: out_height_reg <= pwdata[bir_pkg::OUT_SZ_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            bir_pkg::REG_IN_WIDTH:   prdata = bir_pkg::CFG_DATA_W'(in_width_reg);
            bir_pkg::REG_IN_HEIGHT:  prdata = bir_pkg::CFG_DATA_W'(in_height_reg);
            bir_pkg::REG_OUT_WIDTH:  prdata = bir_pkg::CFG_DATA_W'(out_width_reg);
            bir_pkg::REG_OUT_HEIGHT: prdata = bir_pkg::CFG_DATA_W'(out_height_reg);
        endcase
    end

    // sizes as the datapath uses them
    always_comb
    begin
        cfg.in_w    = bir_pkg::clamp_in(in_width_reg, bir_pkg::IN_SZ_W'(bir_pkg::MAX_IN_W));
        cfg.in_h    = bir_pkg::clamp_in(in_height_reg, bir_pkg::IN_SZ_W'(bir_pkg::MAX_IN_H));
        cfg.out_w   = bir_pkg::clamp_out(out_width_reg,
                                         bir_pkg::OUT_SZ_W'(bir_pkg::MAX_OUT_W));
        cfg.out_h   = bir_pkg::clamp_out(out_height_reg,
                                         bir_pkg::OUT_SZ_W'(bir_pkg::MAX_OUT_H));
        cfg.restart = wr;
    end

    assign s_axis_tready   = !full;
    assign push            = s_axis_tvalid && !full;
    assign push_item.op    = bir_pkg::op_t'(s_axis_tuser);
    assign push_item.pixel = s_axis_tdata;

endmodule

// File: hw/rtl/bir_fifo.sv
// Short item queue between the front end and the datapath.
// Depends on bir_pkg.
module bir_fifo (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bir_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output bir_pkg::item_t pop_item,
    output logic           empty
);

    bir_pkg::item_t              q_mem [bir_pkg::Q_DEPTH];
    logic [bir_pkg::QPTR_W-1:0]  wr_ptr_reg;
    logic [bir_pkg::QPTR_W-1:0]  rd_ptr_reg;
    logic [bir_pkg::QCNT_W-1:0]  count_reg;

    assign full     = (count_reg == bir_pkg::QCNT_W'(bir_pkg::Q_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = q_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == bir_pkg::QPTR_W'(bir_pkg::Q_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == bir_pkg::QPTR_W'(bir_pkg::Q_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// File: hw/rtl/bir_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on bir_pkg.
module bir_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [bir_pkg::DIVIDEND_W-1:0]    dividend,
    input  logic [bir_pkg::DEN_W-1:0]         divisor,
    output logic                              busy,
    output logic [bir_pkg::DIVIDEND_W-1:0]    quotient
);

    logic [bir_pkg::DEN_W-1:0]        rem_reg;
    logic [bir_pkg::DIVIDEND_W-1:0]   quo_reg;
    logic [bir_pkg::STEP_W-1:0]       cnt_reg;
    logic                             run_reg;
    logic [bir_pkg::DEN_W:0]          rem_sh;
    logic                             ge;

    // quo_reg shifts dividend bits out at the top and quotient bits in below
    assign rem_sh   = {rem_reg, quo_reg[bir_pkg::DIVIDEND_W-1]};
    assign ge       = (rem_sh >= {1'b0, divisor});
    assign busy     = run_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (run_reg)
        begin
            // the remainder stays below the divisor, so DEN_W bits hold it
            rem_reg <= ge ? bir_pkg::DEN_W'(rem_sh - {1'b0, divisor}) :
                            rem_sh[bir_pkg::DEN_W-1:0];
            quo_reg <= {quo_reg[bir_pkg::DIVIDEND_W-2:0], ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else if (start)
        begin
            run_reg <= 1'b1;
            cnt_reg <= bir_pkg::STEP_W'(bir_pkg::DIVIDEND_W);
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == bir_pkg::STEP_W'(1))
                run_reg <= 1'b0;
        end
    end

endmodule

// File: hw/rtl/bir_back.sv
// Datapath: frame store, raster counters, coordinate division and
// four-tap accumulation with the output register. Depends on bir_pkg, bir_div.
`include "bilinear_image_resize_defines.svh"
module bir_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  bir_pkg::cfg_t                       cfg,
    input  logic                                empty,
    input  bir_pkg::item_t                      item,
    output logic                                pop,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [bir_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                                m_axis_tlast
);

    localparam logic [bir_pkg::ACC_W-1:0] ROUND =
        bir_pkg::ACC_W'(1) << (2 * bir_pkg::FRAC_W - 1);
    localparam logic [bir_pkg::ACC_W-1:0] ACC_MAX =
        bir_pkg::ACC_W'((64'(1) << bir_pkg::PIXEL_BITS) - 64'(1)) << (2 * bir_pkg::FRAC_W);
    localparam logic [bir_pkg::PIXEL_BITS-1:0] SIGN_FLIP =
        bir_pkg::PIXEL_BITS'(1) << (bir_pkg::PIXEL_BITS - 1);

    bir_pkg::bstate_t state_reg, state_next;

    logic [bir_pkg::COL_W-1:0]  load_col_reg;
    logic [bir_pkg::ROW_W-1:0]  load_row_reg;
    logic [bir_pkg::OCOL_W-1:0] emit_col_reg;
    logic [bir_pkg::OROW_W-1:0] emit_row_reg;
    logic [bir_pkg::TAP_W-1:0]  tap_cnt_reg;
    logic                       out_valid_reg;

    logic [bir_pkg::PIXEL_BITS-1:0] mem [bir_pkg::DEPTH];
    logic [bir_pkg::PIXEL_BITS-1:0] rd_data_reg;
    logic [bir_pkg::ADDR_W-1:0]     rd_addr;
    logic                           mem_we;

    logic [bir_pkg::NUM_W-1:0]  lhs_x_reg, lhs_y_reg;
    logic                       neg_x_reg, neg_y_reg;
    logic [bir_pkg::NUM_W-1:0]  num_x, num_y;
    logic                       div_start;
    logic                       busy_x, busy_y;
    logic [bir_pkg::DIVIDEND_W-1:0] quo_x, quo_y;

    logic [bir_pkg::IDX_W-1:0]  sx_reg, sy_reg;
    logic [bir_pkg::WT_W-1:0]   wx_reg, wy_reg;
    logic [bir_pkg::WT_W-1:0]   wx_sel, wy_sel;
    logic [bir_pkg::W_W-1:0]    w_reg;
    logic [bir_pkg::ACC_W-1:0]  prod_reg, acc_reg, rounded;
    logic [bir_pkg::PIXEL_BITS-1:0] p_biased;
    bir_pkg::coord_t            cx, cy;

    logic [bir_pkg::PIXEL_BITS-1:0] out_pixel_reg;
    logic [bir_pkg::OCOL_W-1:0]     out_col_reg;
    logic [bir_pkg::OROW_W-1:0]     out_row_reg;
    logic                           out_last_reg;
    logic                           out_load;
    logic                           last_col, last_row;

    function automatic bir_pkg::coord_t pick_coord(
        logic                              neg,
        logic [bir_pkg::DIVIDEND_W-1:0]    quo,
        logic [bir_pkg::IN_SZ_W-1:0]       sz
    );
        bir_pkg::coord_t           c;
        logic [bir_pkg::NUM_W-1:0] q;
        q = quo[bir_pkg::DIVIDEND_W-1 -: bir_pkg::NUM_W];
        if (neg)
        begin
            c.idx = '0;
            c.wt  = '0;
        end
        else if (q >= bir_pkg::NUM_W'(sz - bir_pkg::IN_SZ_W'(1)))
        begin
            // past the last pair of pixels: stick to the right-hand one
            c.idx = bir_pkg::IDX_W'(sz - bir_pkg::IN_SZ_W'(2));
            c.wt  = bir_pkg::ONE_Q;
        end
        else
        begin
            c.idx = q[bir_pkg::IDX_W-1:0];
            c.wt  = {1'b0, quo[bir_pkg::FRAC_W-1:0]};
        end
        return c;
    endfunction

    // position numerator (2d+1)*in - out; the 0.16 fraction comes from the shift
    assign num_x = lhs_x_reg - bir_pkg::NUM_W'(cfg.out_w);
    assign num_y = lhs_y_reg - bir_pkg::NUM_W'(cfg.out_h);

    bir_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({num_x, {bir_pkg::FRAC_W{1'b0}}}),
        .divisor  ({cfg.out_w, 1'b0}),
        .busy     (busy_x),
        .quotient (quo_x)
    );

    bir_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({num_y, {bir_pkg::FRAC_W{1'b0}}}),
        .divisor  ({cfg.out_h, 1'b0}),
        .busy     (busy_y),
        .quotient (quo_y)
    );

    assign cx = pick_coord(neg_x_reg, quo_x, cfg.in_w);
    assign cy = pick_coord(neg_y_reg, quo_y, cfg.in_h);

    // tap order: (y0,x0) (y0,x1) (y1,x0) (y1,x1)
    assign rd_addr = {bir_pkg::ROW_W'(sy_reg + bir_pkg::IDX_W'(tap_cnt_reg[1])),
                      bir_pkg::COL_W'(sx_reg + bir_pkg::IDX_W'(tap_cnt_reg[0]))};
    assign wx_sel  = tap_cnt_reg[0] ? wx_reg : bir_pkg::ONE_Q - wx_reg;
    assign wy_sel  = tap_cnt_reg[1] ? wy_reg : bir_pkg::ONE_Q - wy_reg;
    assign p_biased = rd_data_reg ^ SIGN_FLIP;
    assign rounded  = acc_reg + ROUND;

    assign last_col = (bir_pkg::OUT_SZ_W'(emit_col_reg) + 1'b1 >= cfg.out_w);
    assign last_row = (bir_pkg::OUT_SZ_W'(emit_row_reg) + 1'b1 >= cfg.out_h);

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        mem_we     = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (state_reg)
            bir_pkg::B_IDLE:
            begin
                if (!empty)
                begin
                    pop = 1'b1;
                    if (item.op == bir_pkg::OP_EMIT)
                        state_next = bir_pkg::B_PREP;
                    else
                        mem_we = 1'b1;
                end
            end
            bir_pkg::B_PREP:  state_next = bir_pkg::B_START;
            bir_pkg::B_START:
            begin
                div_start  = 1'b1;
                state_next = bir_pkg::B_DIV;
            end
            bir_pkg::B_DIV:
            begin
                if (!busy_x && !busy_y)
                    state_next = bir_pkg::B_ADDR;
            end
            bir_pkg::B_ADDR:  state_next = bir_pkg::B_MAC;
            bir_pkg::B_MAC:
            begin
                if (tap_cnt_reg == bir_pkg::TAP_LAST)
                    state_next = bir_pkg::B_RES;
            end
            bir_pkg::B_RES:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = bir_pkg::B_IDLE;
                end
            end
            default: state_next = bir_pkg::B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= bir_pkg::B_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            load_col_reg  <= '0;
            load_row_reg  <= '0;
            emit_col_reg  <= '0;
            emit_row_reg  <= '0;
            tap_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.restart)
            begin
                load_col_reg <= '0;
                load_row_reg <= '0;
            end
            else if (mem_we)
            begin
                if (bir_pkg::IN_SZ_W'(load_col_reg) + 1'b1 >= cfg.in_w)
                begin
                    load_col_reg <= '0;
                    load_row_reg <= (bir_pkg::IN_SZ_W'(load_row_reg) + 1'b1 >= cfg.in_h) ?
                                    '0 : load_row_reg + 1'b1;
                end
                else
                    load_col_reg <= load_col_reg + 1'b1;
            end

            if (cfg.restart)
            begin
                emit_col_reg <= '0;
                emit_row_reg <= '0;
            end
            else if (out_load)
            begin
                if (last_col)
                begin
                    emit_col_reg <= '0;
                    emit_row_reg <= last_row ? '0 : emit_row_reg + 1'b1;
                end
                else
                    emit_col_reg <= emit_col_reg + 1'b1;
            end

            if (state_reg == bir_pkg::B_ADDR)
                tap_cnt_reg <= '0;
            else if (state_reg == bir_pkg::B_MAC)
                tap_cnt_reg <= tap_cnt_reg + 1'b1;

            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // frame store
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[{load_row_reg, load_col_reg}] <= item.pixel;
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == bir_pkg::B_PREP)
        begin
            lhs_x_reg <= bir_pkg::NUM_W'({emit_col_reg, 1'b1}) * bir_pkg::NUM_W'(cfg.in_w);
            lhs_y_reg <= bir_pkg::NUM_W'({emit_row_reg, 1'b1}) * bir_pkg::NUM_W'(cfg.in_h);
        end
        if (state_reg == bir_pkg::B_START)
        begin
            neg_x_reg <= (lhs_x_reg < bir_pkg::NUM_W'(cfg.out_w));
            neg_y_reg <= (lhs_y_reg < bir_pkg::NUM_W'(cfg.out_h));
        end
        if (state_reg == bir_pkg::B_ADDR)
        begin
            sx_reg  <= cx.idx;
            wx_reg  <= cx.wt;
            sy_reg  <= cy.idx;
            wy_reg  <= cy.wt;
            acc_reg <= '0;
        end
        if (state_reg == bir_pkg::B_MAC)
        begin
            // three-deep pipe: weight product, pixel product, accumulate
            w_reg <= bir_pkg::W_W'(bir_pkg::W_W'(wy_sel) * bir_pkg::W_W'(wx_sel));
            if (w_reg[bir_pkg::W_W-1])
                prod_reg <= {p_biased, {(2 * bir_pkg::FRAC_W){1'b0}}};
            else
                prod_reg <= bir_pkg::ACC_W'(p_biased) *
                            bir_pkg::ACC_W'(w_reg[2*bir_pkg::FRAC_W-1:0]);
            if (tap_cnt_reg >= bir_pkg::TAP_W'(2))
                acc_reg <= acc_reg + prod_reg;
        end
        if (out_load)
        begin
            out_pixel_reg <= rounded[bir_pkg::ACC_W-1 -: bir_pkg::PIXEL_BITS] ^ SIGN_FLIP;
            out_col_reg   <= emit_col_reg;
            out_row_reg   <= emit_row_reg;
            out_last_reg  <= last_col && last_row;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = bir_pkg::OUT_TDATA_W'({out_row_reg, out_col_reg, out_pixel_reg});

    `BIR_ASSERT(a_acc_bound, (state_reg == bir_pkg::B_RES) |-> (acc_reg <= ACC_MAX))
    `BIR_ASSERT(a_sx_ok, (state_reg == bir_pkg::B_MAC) |-> ({1'b0, sx_reg} <= cfg.in_w - 2'd2))
    `BIR_ASSERT(a_sy_ok, (state_reg == bir_pkg::B_MAC) |-> ({1'b0, sy_reg} <= cfg.in_h - 2'd2))
    `BIR_ASSERT_NEXT(a_div_runs, state_reg == bir_pkg::B_START, busy_x && busy_y)

endmodule

// File: hw/rtl/bilinear_image_resize.sv
// Bilinear resize of one image plane with half-pixel centers: top level.
// Depends on bir_pkg, bir_front, bir_fifo, bir_back.
//
// Load transfers (tuser 0) write source pixels in raster order into a
// 128x128 frame store, each as the datapath pops it while idle. Emit
// transfers (tuser 1) return the next output pixel in raster order: the
// source coordinate and its 0.16 weight come out of a bit-serial divider
// that runs 35 steps per emit (x and y in parallel), then the four
// neighbors are read from the store and accumulated; the datapath takes
// no new item until the result is loaded. A two-entry queue in front and a
// result register behind let the input and output sides stall on their
// own. Any register write restarts the load and emit raster positions; the
// source plane must be loaded before it is emitted.
module bilinear_image_resize (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [bir_pkg::CFG_ADDR_W-1:0]         paddr,
    input  logic [bir_pkg::CFG_DATA_W-1:0]         pwdata,
    output logic [bir_pkg::CFG_DATA_W-1:0]         prdata,
    output logic                                   pready,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [bir_pkg::PIXEL_BITS-1:0]         s_axis_tdata,  // pixel_in
    input  logic                                   s_axis_tuser,  // operation
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // pixel_out, out_col, out_row, zero fill
    output logic [bir_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
    output logic                                   m_axis_tlast   // plane_done
);

    logic           push, pop, full, empty;
    bir_pkg::item_t push_item, pop_item;
    bir_pkg::cfg_t  cfg;

    bir_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .push          (push),
        .push_item     (push_item),
        .full          (full),
        .cfg           (cfg)
    );

    bir_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (empty)
    );

    bir_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .empty         (empty),
        .item          (pop_item),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

endmodule

// File: dv/bir_checker.sv
// Scoreboard for the bilinear resize block: follows register writes and input
// transfers, predicts each output pixel and compares it with the output stream.
// Depends on bir_pkg.
module bir_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bir_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [bir_pkg::CFG_DATA_W-1:0]      pwdata,
    input  logic                                pready,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic [bir_pkg::PIXEL_BITS-1:0]      s_axis_tdata,
    input  logic                                s_axis_tuser,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [bir_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                m_axis_tlast,
    output int                                  errors,
    output int                                  outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [15:0] pixel;
        logic [9:0]  col;
        logic [9:0]  row;
        logic        last;
    } out_px_t;

    logic [bir_pkg::PIXEL_BITS-1:0] src_plane [bir_pkg::DEPTH];
    logic [7:0]  reg_iw, reg_ih;
    logic [10:0] reg_ow, reg_oh;
    int unsigned ld_col, ld_row, em_col, em_row;
    out_px_t     pending_pixels [$];

    task automatic report(string what, int got, int want);
        $display("%0t ns: mismatch %s: got %0d expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    function automatic int unsigned clip(int unsigned v, int unsigned lo, int unsigned hi);
        return (v < lo) ? lo : (v > hi) ? hi : v;
    endfunction

    // source index and 0.16 weight for output coordinate d
    function automatic void src_coord(input int unsigned d, input int unsigned n_in,
                                      input int unsigned n_out,
                                      output int unsigned idx, output int unsigned wt);
        longint unsigned lhs, den, num, q;
        lhs = (2 * longint'(d) + 1) * n_in;
        den = 2 * longint'(n_out);
        if (lhs < n_out) begin
            idx = 0;
            wt  = 0;
        end else begin
            num = lhs - n_out;
            q   = num / den;
            if (q >= n_in - 1) begin
                idx = n_in - 2;
                wt  = 65536;
            end else begin
                idx = q;
                wt  = ((num % den) << 16) / den;
            end
        end
    endfunction

    function automatic longint unsigned biased(int unsigned r, int unsigned c);
        return longint'(16'(src_plane[(r % bir_pkg::MAX_IN_H) * bir_pkg::MAX_IN_W
                                      + (c % bir_pkg::MAX_IN_W)] + 16'h8000));
    endfunction

    function automatic out_px_t interpolate();
        int unsigned iw, ih, ow, oh, sx, fx, sy, fy;
        longint unsigned acc;
        out_px_t p;
        iw = clip(reg_iw, 2, bir_pkg::MAX_IN_W);
        ih = clip(reg_ih, 2, bir_pkg::MAX_IN_H);
        ow = clip(reg_ow, 1, bir_pkg::MAX_OUT_W);
        oh = clip(reg_oh, 1, bir_pkg::MAX_OUT_H);
        src_coord(em_col, iw, ow, sx, fx);
        src_coord(em_row, ih, oh, sy, fy);
        acc = biased(sy, sx) * ((65536 - fy) * longint'(65536 - fx))
            + biased(sy, sx + 1) * ((65536 - fy) * longint'(fx))
            + biased(sy + 1, sx) * (longint'(fy) * (65536 - fx))
            + biased(sy + 1, sx + 1) * (longint'(fy) * fx);
        p.pixel = 16'((acc + (64'd1 << 31)) >> 32) - 16'h8000;
        p.col   = 10'(em_col);
        p.row   = 10'(em_row);
        p.last  = (em_col + 1 >= ow) && (em_row + 1 >= oh);
        if (em_col + 1 >= ow) begin
            em_col = 0;
            em_row = (em_row + 1 >= oh) ? 0 : em_row + 1;
        end else
            em_col++;
        return p;
    endfunction

    initial
    begin
        foreach (src_plane[i]) src_plane[i] = '0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        out_px_t want;
        if (!rst_n) begin
            reg_iw = 128; reg_ih = 128; reg_ow = 128; reg_oh = 128;
            ld_col = 0; ld_row = 0; em_col = 0; em_row = 0;
            pending_pixels.delete();
            errors = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (bir_pkg::reg_idx_t'(paddr[3:2]))
                    bir_pkg::REG_IN_WIDTH:   reg_iw = pwdata[7:0];
                    bir_pkg::REG_IN_HEIGHT:  reg_ih = pwdata[7:0];
                    bir_pkg::REG_OUT_WIDTH:  reg_ow = pwdata[10:0];
                    bir_pkg::REG_OUT_HEIGHT: reg_oh = pwdata[10:0];
                endcase
                ld_col = 0; ld_row = 0; em_col = 0; em_row = 0;
            end
            if (s_axis_tvalid && s_axis_tready) begin
                if (bir_pkg::op_t'(s_axis_tuser) == bir_pkg::OP_LOAD) begin
                    src_plane[ld_row * bir_pkg::MAX_IN_W + ld_col] = s_axis_tdata;
                    if (ld_col + 1 >= clip(reg_iw, 2, bir_pkg::MAX_IN_W)) begin
                        ld_col = 0;
                        ld_row = (ld_row + 1 >= clip(reg_ih, 2, bir_pkg::MAX_IN_H)) ?
                                 0 : ld_row + 1;
                    end else
                        ld_col++;
                end else
                    pending_pixels.push_back(interpolate());
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_pixels.size() == 0)
                    report("unexpected output transfer", m_axis_tdata[15:0], 0);
                else begin
                    want = pending_pixels.pop_front();
                    if (m_axis_tdata[15:0] !== want.pixel)
                        report("pixel_out", $signed(m_axis_tdata[15:0]), $signed(want.pixel));
                    if (m_axis_tdata[25:16] !== want.col)
                        report("out_col", m_axis_tdata[25:16], want.col);
                    if (m_axis_tdata[35:26] !== want.row)
                        report("out_row", m_axis_tdata[35:26], want.row);
                    if (m_axis_tlast !== want.last)
                        report("plane_done", m_axis_tlast, want.last);
                end
            end
        end
        outstanding = pending_pixels.size();
    end

endmodule

// File: dv/tb_bilinear_image_resize.sv
// Testbench top for bilinear_image_resize: drives register writes and pixel
// streams with random gaps and back-pressure; bir_checker does the checking.
// Depends on bir_pkg, bilinear_image_resize and bir_checker.
module tb_bilinear_image_resize;
    timeunit 1ns;
    timeprecision 1ps;

    logic                             clk = 1'b0;
    logic                             rst_n = 1'b0;
    logic                             psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [bir_pkg::CFG_ADDR_W-1:0]   paddr = '0;
    logic [bir_pkg::CFG_DATA_W-1:0]   pwdata = '0;
    logic [bir_pkg::CFG_DATA_W-1:0]   prdata;
    logic                             pready;
    logic                             s_axis_tvalid = 1'b0, s_axis_tready;
    logic [bir_pkg::PIXEL_BITS-1:0]   s_axis_tdata = '0;
    logic                             s_axis_tuser = 1'b0;
    logic                             m_axis_tvalid, m_axis_tready = 1'b0;
    logic [bir_pkg::OUT_TDATA_W-1:0]  m_axis_tdata;
    logic                             m_axis_tlast;
    logic                             in_taken = 1'b0;
    logic                             steady = 1'b0;
    int                               errors, outstanding;
    int                               n_items = 0;

    always #1 clk = ~clk;

    bilinear_image_resize uut (.*);
    bir_checker checker_i (.*);

    always @(posedge clk) in_taken <= s_axis_tvalid && s_axis_tready;

    always @(negedge clk) m_axis_tready <= steady || $urandom_range(99) >= 16;

    task automatic cfg_write(bir_pkg::reg_idx_t idx, int unsigned value);
        @(negedge clk);
        psel <= 1'b1; pwrite <= 1'b1; pwdata <= value;
        paddr <= bir_pkg::CFG_ADDR_W'(idx) << 2;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    endtask

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(bir_pkg::op_t op, logic [15:0] pixel);
        if (!steady && $urandom_range(99) < 16) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= pixel;
        do @(negedge clk); while (!in_taken);
        n_items++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    // drains, then writes all registers and loads a full source plane of random pixels
    task automatic new_plane(int unsigned iw, int unsigned ih, int unsigned ow, int unsigned oh);
        int unsigned n;
        drain();
        cfg_write(bir_pkg::REG_IN_WIDTH, iw);
        cfg_write(bir_pkg::REG_IN_HEIGHT, ih);
        cfg_write(bir_pkg::REG_OUT_WIDTH, ow);
        cfg_write(bir_pkg::REG_OUT_HEIGHT, oh);
        n = ((iw < 2) ? 2 : (iw > 128) ? 128 : iw) * ((ih < 2) ? 2 : (ih > 128) ? 128 : ih);
        repeat (n) send_item(bir_pkg::OP_LOAD, 16'($urandom));
    endtask

    initial
    begin
        int unsigned phase;
        logic [15:0] corners [4] = '{16'h7fff, 16'h8000, 16'h0000, 16'hffff};
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // upsampling 2x2 to 3x5 hits both clamps and the extreme pixel values
        cfg_write(bir_pkg::REG_IN_WIDTH, 2);
        cfg_write(bir_pkg::REG_IN_HEIGHT, 2);
        cfg_write(bir_pkg::REG_OUT_WIDTH, 3);
        cfg_write(bir_pkg::REG_OUT_HEIGHT, 5);
        foreach (corners[i]) send_item(bir_pkg::OP_LOAD, corners[i]);
        repeat (15) send_item(bir_pkg::OP_EMIT, 16'($urandom));

        phase = 0;
        while (n_items < 1550) begin
            steady = (phase >= 6 && phase < 9);
            case (phase)
                0: new_plane(255, 0, 2047, 1);     // widths clamp to 128 and 1024
                1: new_plane(1, 128, 0, 0);        // sizes clamp to 2 and 1
                2: new_plane(128, 2, 1024, 3);
                3: new_plane(2, 128, 1, 1024);
                default: new_plane($urandom_range(2, 8), $urandom_range(2, 8),
                                   $urandom_range(1, 14), $urandom_range(1, 14));
            endcase
            repeat ($urandom_range(20, 60))
                send_item(($urandom_range(3) == 0) ? bir_pkg::OP_LOAD : bir_pkg::OP_EMIT,
                          16'($urandom));
            phase++;
        end
        steady = 1'b0;
        drain();

        if (errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Some tests failed");
        $finish;
    end

endmodule
